>>> hw/rtl/gaussian_kde_windowed_defines.svh
// assertion macros for the windowed kernel density estimator
// used by the checker bound to gaussian_kde_windowed, needs clk and rst_n in scope
`ifndef GAUSSIAN_KDE_WINDOWED_DEFINES_SVH
`define GAUSSIAN_KDE_WINDOWED_DEFINES_SVH

// same cycle implication, off during reset
`define GKDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next cycle implication, off during reset
`define GKDE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next cycle implication, also active in reset
`define GKDE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/gkde_pkg.sv
// shared types, constants and kernel rom for the windowed kernel density estimator
// no dependencies
package gkde_pkg;

  localparam int MAX_SAMPLES       = 1024;
  localparam int KERNEL_TABLE_SIZE = 256;
  localparam int ADDR_W            = $clog2(MAX_SAMPLES);
  localparam int CNT_W             = $clog2(MAX_SAMPLES + 1);
  localparam int KIDX_W            = $clog2(KERNEL_TABLE_SIZE);
  localparam int KV_W              = 17;
  localparam int ACC_W             = CNT_W + 16;
  localparam int PROD_W            = ACC_W + 32;
  localparam int DIV_CELLS         = 4;
  localparam int DIV_STEPS         = (PROD_W + DIV_CELLS - 1) / DIV_CELLS;
  localparam int DIV_W             = DIV_STEPS * DIV_CELLS;
  localparam int STEP_W            = $clog2(DIV_STEPS + 1);
  localparam int FRAC_SHIFT        = 24;
  localparam int CFG_IDX_W         = 2;
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_CLEAR = 2'd0;
  localparam opcode_t OP_LOAD  = 2'd1;
  localparam opcode_t OP_QUERY = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_HALF_WINDOW = 2'd0;
  localparam cfg_idx_t REG_INV_TWO_VAR = 2'd1;
  localparam cfg_idx_t REG_INV_NORM    = 2'd2;

  localparam logic [30:0] HALF_WINDOW_RST = 31'd196608;
  localparam logic [31:0] INV_TWO_VAR_RST = 32'd8388608;
  localparam logic [31:0] INV_NORM_RST    = 32'd6693161;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } wr_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef logic [31:0] krom_t [KERNEL_TABLE_SIZE];

  function automatic logic [31:0] rom_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] ef;
    logic [63:0] en;
    logic signed [65:0] s;
    x = (64'(i) << 35) / KERNEL_TABLE_SIZE;
    n = x >> 32;
    f = x & 64'hFFFF_FFFF;
    t = 64'd1 << 32;
    s = 66'sd4294967296;
    t = (t * f) >> 32;          s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 2;    s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 3;    s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 4;    s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 5;    s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 6;    s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 7;    s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 8;    s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 9;    s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 10;   s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 11;   s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 12;   s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 13;   s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 14;   s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 15;   s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 16;   s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 17;   s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 18;   s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 19;   s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 20;   s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 21;   s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 22;   s = s + $signed({2'b00, t});
    t = ((t * f) >> 32) / 23;   s = s - $signed({2'b00, t});
    t = ((t * f) >> 32) / 24;   s = s + $signed({2'b00, t});
    if (s < 0) s = 0;
    if (s > 66'sh0_FFFF_FFFF) s = 66'sh0_FFFF_FFFF;
    ef = 64'(s);
    en = 64'hFFFF_FFFF;
    for (int k = 0; k < 8; k++) begin
      if (64'(k) < n) en = (en * EXP_M1_Q32) >> 32;
    end
    return 32'((((ef * en) >> 32) + 64'd32768) >> 16);
  endfunction

  function automatic krom_t build_krom();
    krom_t r;
    for (int i = 0; i < KERNEL_TABLE_SIZE; i++) begin
      r[i] = rom_entry(i);
    end
    return r;
  endfunction

  localparam krom_t KROM = build_krom();

endpackage

>>> hw/rtl/gkde_in_if.sv
// input item channel: opcode and position
// depends on gkde_pkg
interface gkde_in_if;
  logic               valid;
  logic               ready;
  gkde_pkg::opcode_t  opcode;
  logic signed [31:0] value;
  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

>>> hw/rtl/gkde_out_if.sv
// result item channel: density and empty flag
// no dependencies
interface gkde_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] density;
  logic        empty_flag;
  modport source (output valid, output density, output empty_flag, input ready);
  modport sink (input valid, input density, input empty_flag, output ready);
endinterface

>>> hw/rtl/gkde_cfg_if.sv
// register write channel: index and data
// depends on gkde_pkg
interface gkde_cfg_if;
  logic               valid;
  logic               ready;
  gkde_pkg::cfg_idx_t index;
  logic [31:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/gkde_store.sv
// sample store: one write port, one registered read port
// depends on gkde_pkg
module gkde_store (
  input  logic                        clk,
  input  gkde_pkg::wr_t               wr,
  input  logic [gkde_pkg::ADDR_W-1:0] rd_addr,
  output logic [31:0]                 rd_data_r
);
  logic [31:0] mem [gkde_pkg::MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end
endmodule

>>> hw/rtl/gkde_kernel.sv
// pipelined truncated gaussian kernel, one sample per cycle, five stages
// depends on gkde_pkg (kernel rom and widths)
module gkde_kernel (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_v,
  input  logic [31:0]               sample,
  input  logic [31:0]               query,
  input  logic [30:0]               half_window,
  input  logic [31:0]               inv_two_var,
  output logic                      kv_v_r,
  output logic [gkde_pkg::KV_W-1:0] kv_r,
  output logic                      busy
);
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [61:0]        sq;
  logic [69:0]        t;

  logic                      v1_r, v2_r, v3_r, v4_r;
  logic                      w1_r, w2_r, w3_r, ok4_r;
  logic [30:0]               mag_r;
  logic [37:0]               sq8_r;
  logic [63:0]               plo_r;
  logic [37:0]               phi_r;
  logic [gkde_pkg::KIDX_W-1:0] idx_r;

  assign diff = $signed({sample[31], sample}) - $signed({query[31], query});
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);
  assign sq   = mag_r * mag_r;
  assign t    = {6'd0, plo_r} + {phi_r, 32'd0};
  assign busy = v1_r | v2_r | v3_r | v4_r | kv_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      kv_v_r <= 1'b0;
    end else begin
      v1_r   <= in_v;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      kv_v_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag[30:0];
    w1_r  <= mag < {2'b00, half_window};
    sq8_r <= sq[61:24];
    w2_r  <= w1_r;
    plo_r <= sq8_r[31:0] * inv_two_var;
    phi_r <= 38'(sq8_r[37:32]) * 38'(inv_two_var);
    w3_r  <= w2_r;
    ok4_r <= w3_r && (t[69:35] == '0);
    idx_r <= t[34 -: gkde_pkg::KIDX_W];
    kv_r  <= ok4_r ? gkde_pkg::KROM[idx_r][gkde_pkg::KV_W-1:0] : '0;
  end
endmodule

>>> hw/rtl/gkde_div_cell.sv
// one restoring division cell: shifts in one dividend bit, yields one quotient bit
// depends on gkde_pkg
module gkde_div_cell (
  input  logic [gkde_pkg::CNT_W-1:0] rem_in,
  input  logic                       bit_in,
  input  logic [gkde_pkg::CNT_W-1:0] divisor,
  output logic [gkde_pkg::CNT_W-1:0] rem_out,
  output logic                       q_out
);
  logic [gkde_pkg::CNT_W:0] trial;
  logic [gkde_pkg::CNT_W:0] diff;

  assign trial   = {rem_in, bit_in};
  assign diff    = trial - {1'b0, divisor};
  assign q_out   = trial >= {1'b0, divisor};
  assign rem_out = q_out ? diff[gkde_pkg::CNT_W-1:0] : trial[gkde_pkg::CNT_W-1:0];
endmodule

>>> hw/rtl/gkde_divider.sv
// iterative divider: product of sum and scale over sample count,
// a chain of division cells gives several quotient bits per cycle
// depends on gkde_pkg, gkde_div_cell
module gkde_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gkde_pkg::div_ctl_t         ctl,
  input  logic [gkde_pkg::ACC_W-1:0] acc,
  input  logic [31:0]                scale,
  input  logic [gkde_pkg::CNT_W-1:0] divisor,
  output gkde_pkg::div_sts_t         sts,
  output logic [gkde_pkg::DIV_W-1:0] quot
);
  logic [gkde_pkg::DIV_W-1:0]  work_r;
  logic [gkde_pkg::CNT_W-1:0]  rem_r;
  logic [gkde_pkg::STEP_W-1:0] step_r;
  logic                        busy_r;
  logic                        done_r;
  logic [gkde_pkg::PROD_W-1:0] prod;
  logic [gkde_pkg::CNT_W-1:0]  rem_c [gkde_pkg::DIV_CELLS+1];
  logic [gkde_pkg::DIV_CELLS-1:0] qbits;

  assign prod     = acc * scale;
  assign rem_c[0] = rem_r;

  for (genvar g = 0; g < gkde_pkg::DIV_CELLS; g++) begin : g_cell
    gkde_div_cell u_cell (
      .rem_in  (rem_c[g]),
      .bit_in  (work_r[gkde_pkg::DIV_W-1-g]),
      .divisor (divisor),
      .rem_out (rem_c[g+1]),
      .q_out   (qbits[gkde_pkg::DIV_CELLS-1-g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !ctl.start && busy_r
                && (step_r == gkde_pkg::STEP_W'(gkde_pkg::DIV_STEPS - 1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == gkde_pkg::STEP_W'(gkde_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      work_r <= gkde_pkg::DIV_W'(prod);
      rem_r  <= '0;
    end else if (busy_r) begin
      work_r <= {work_r[gkde_pkg::DIV_W-gkde_pkg::DIV_CELLS-1:0], qbits};
      rem_r  <= rem_c[gkde_pkg::DIV_CELLS];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = work_r;
endmodule

>>> hw/rtl/gaussian_kde_windowed.sv
// channel   dir  handshake     payload
// in_ch     in   valid/ready   opcode, value
// out_ch    out  valid/ready   density, empty_flag
// cfg_ch    in   valid/ready   index, data
// clear and load are done in the idle state; a query scans the stored samples through the
// single store read port, drains the kernel pipeline, then runs the divider and a finish state.
// a query on an empty store skips the scan and the divider and goes straight to the finish state.
// synchronous active low reset clears count and state and sets the config registers to defaults;
// the store needs no clearing. a result waiting on out_ch does not block loads; only a finishing
// query waits for it. depends on gkde_pkg, the channel interfaces, gkde_store, gkde_kernel, gkde_divider
module gaussian_kde_windowed (
  input  logic       clk,
  input  logic       rst_n,
  gkde_in_if.sink    in_ch,
  gkde_out_if.source out_ch,
  gkde_cfg_if.sink   cfg_ch
);
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t                      state_r;
  logic [gkde_pkg::CNT_W-1:0]  count_r;
  logic [gkde_pkg::CNT_W-1:0]  idx_r;
  logic [31:0]                 query_r;
  logic [gkde_pkg::ACC_W-1:0]  acc_r;
  logic                        empty_r;
  logic                        rv_r;
  logic [30:0]                 half_window_r;
  logic [31:0]                 inv_two_var_r;
  logic [31:0]                 inv_norm_r;
  logic                        out_valid_r;
  logic [31:0]                 out_density_r;
  logic                        out_empty_r;

  gkde_pkg::wr_t               wr;
  logic [gkde_pkg::ADDR_W-1:0] rd_addr;
  logic [31:0]                 rd_data;
  logic                        kv_v;
  logic [gkde_pkg::KV_W-1:0]   kv;
  logic                        k_busy;
  gkde_pkg::div_ctl_t          div_ctl;
  gkde_pkg::div_sts_t          div_sts;
  logic [gkde_pkg::DIV_W-1:0]  quot;
  logic                        in_acc;
  logic                        slot_free;
  logic [31:0]                 dens;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign slot_free    = !out_valid_r || out_ch.ready;

  assign wr.en   = in_acc && (in_ch.opcode == gkde_pkg::OP_LOAD)
                   && (count_r < gkde_pkg::CNT_W'(gkde_pkg::MAX_SAMPLES));
  assign wr.addr = count_r[gkde_pkg::ADDR_W-1:0];
  assign wr.data = in_ch.value;
  assign rd_addr = idx_r[gkde_pkg::ADDR_W-1:0];

  assign div_ctl.start = (state_r == ST_DRAIN) && !rv_r && !k_busy;

  always_comb begin
    if (empty_r) begin
      dens = '0;
    end else if (quot[gkde_pkg::DIV_W-1:gkde_pkg::FRAC_SHIFT+32] != '0) begin
      dens = '1;
    end else begin
      dens = quot[gkde_pkg::FRAC_SHIFT+31:gkde_pkg::FRAC_SHIFT];
    end
  end

  gkde_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  gkde_kernel u_kernel (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_v        (rv_r),
    .sample      (rd_data),
    .query       (query_r),
    .half_window (half_window_r),
    .inv_two_var (inv_two_var_r),
    .kv_v_r      (kv_v),
    .kv_r        (kv),
    .busy        (k_busy)
  );

  gkde_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .acc     (acc_r),
    .scale   (inv_norm_r),
    .divisor (count_r),
    .sts     (div_sts),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_window_r <= gkde_pkg::HALF_WINDOW_RST;
      inv_two_var_r <= gkde_pkg::INV_TWO_VAR_RST;
      inv_norm_r    <= gkde_pkg::INV_NORM_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        gkde_pkg::REG_HALF_WINDOW: half_window_r <= cfg_ch.data[30:0];
        gkde_pkg::REG_INV_TWO_VAR: inv_two_var_r <= cfg_ch.data;
        gkde_pkg::REG_INV_NORM:    inv_norm_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r <= (state_r == ST_SCAN);
      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_ch.opcode)
              gkde_pkg::OP_CLEAR: count_r <= '0;
              gkde_pkg::OP_LOAD: begin
                if (wr.en) count_r <= count_r + 1'b1;
              end
              gkde_pkg::OP_QUERY: begin
                idx_r   <= '0;
                state_r <= (count_r == '0) ? ST_FIN : ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == count_r - 1'b1) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (div_ctl.start) state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_sts.done) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.opcode == gkde_pkg::OP_QUERY)) begin
      query_r <= in_ch.value;
      acc_r   <= '0;
      empty_r <= (count_r == '0);
    end else if (kv_v) begin
      acc_r <= acc_r + gkde_pkg::ACC_W'(kv);
    end
    if ((state_r == ST_FIN) && slot_free) begin
      out_density_r <= dens;
      out_empty_r   <= empty_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.density    = out_density_r;
  assign out_ch.empty_flag = out_empty_r;
endmodule

>>> hw/rtl/gkde_checker.sv
// port level checks for gaussian_kde_windowed, attached by bind
// depends on gkde_pkg and gaussian_kde_windowed_defines.svh
`include "gaussian_kde_windowed_defines.svh"

module gkde_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input gkde_pkg::opcode_t in_opcode,
  input logic              out_valid,
  input logic              out_ready,
  input logic [31:0]       out_density,
  input logic              out_empty
);
  `GKDE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_density) && $stable(out_empty), "result item changed while stalled")
  `GKDE_ASSERT_IMP(a_empty_zero, out_valid && out_empty, out_density == 32'd0, "empty store result with nonzero density")
  `GKDE_ASSERT_NXT(a_query_busy, in_valid && in_ready && (in_opcode == gkde_pkg::OP_QUERY), !in_ready, "input ready right after a query item")
  `GKDE_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid, "result item valid after reset")
endmodule

bind gaussian_kde_windowed gkde_checker u_gkde_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_opcode   (in_ch.opcode),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_density (out_ch.density),
  .out_empty   (out_ch.empty_flag)
);

>>> tb/sv/tb_gaussian_kde_windowed.sv
`timescale 1ns / 100ps
// self-checking testbench for gaussian_kde_windowed: clear, load and query items with
// random idling on both channels, densities predicted by an in-bench kernel density model
// depends on gkde_pkg, gkde_in_if, gkde_out_if, gkde_cfg_if and the rtl under hw/rtl
module tb_gaussian_kde_windowed;

  localparam gkde_pkg::opcode_t  OP_NONE    = 2'd3;
  localparam gkde_pkg::cfg_idx_t REG_NONE   = 2'd3;
  localparam int                 DRAIN_WAIT = 1200;
  localparam int                 CYCLE_CAP  = 3000000;

  typedef struct {
    gkde_pkg::opcode_t op;
    logic [31:0]       pos;
  } kde_item_t;

  typedef struct {
    logic [31:0] density;
    logic        empty_flag;
  } kde_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gkde_in_if  in_bus();
  gkde_out_if out_bus();
  gkde_cfg_if cfg_bus();

  gaussian_kde_windowed DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #4 clk = ~clk;

  kde_item_t   pending_items[$];
  kde_answer_t awaited_answers[$];

  logic [31:0] kern_rom [gkde_pkg::KERNEL_TABLE_SIZE];
  logic [31:0] mdl_store [gkde_pkg::MAX_SAMPLES];
  int unsigned mdl_count = 0;
  logic [30:0] mdl_half_window = gkde_pkg::HALF_WINDOW_RST;
  logic [31:0] mdl_inv_two_var = gkde_pkg::INV_TWO_VAR_RST;
  logic [31:0] mdl_inv_norm    = gkde_pkg::INV_NORM_RST;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int n_queries = 0;
  int n_loads = 0;
  int n_answers = 0;
  int n_cfg = 0;
  int unsigned cycles = 0;
  logic in_taken = 1'b0;

  function automatic logic [31:0] exp_level(int i);
    logic [127:0]        x;
    logic [127:0]        n;
    logic [127:0]        f;
    logic [127:0]        term;
    logic [127:0]        ef;
    logic [127:0]        en;
    logic signed [127:0] s;
    x = (128'(i) << 35) / gkde_pkg::KERNEL_TABLE_SIZE;
    n = x >> 32;
    f = x & 128'hFFFF_FFFF;
    term = 128'd1 << 32;
    s = $signed(term);
    for (int k = 1; k <= 24; k++) begin
      term = ((term * f) >> 32) / k;
      if (k % 2 == 1) s = s - $signed(term);
      else s = s + $signed(term);
    end
    if (s < 0) s = 0;
    ef = s;
    if (ef > 128'hFFFF_FFFF) ef = 128'hFFFF_FFFF;
    en = 128'hFFFF_FFFF;
    for (int k = 0; k < n; k++) en = (en * 128'd1580030169) >> 32;
    return 32'((((ef * en) >> 32) + 128'd32768) >> 16);
  endfunction

  function automatic logic [31:0] kernel_weight(logic [63:0] mag);
    logic [127:0] sq;
    logic [127:0] t;
    sq = (128'(mag) * 128'(mag)) >> 24;
    t = sq * 128'(mdl_inv_two_var);
    if (t > 128'hFFFF_FFFF_FFFF_FFFF) return 32'd0;
    if (t >= (128'd8 << 32)) return 32'd0;
    return kern_rom[int'(t >> 27)];
  endfunction

  function automatic kde_answer_t density_at(logic [31:0] q);
    kde_answer_t         a;
    logic signed [33:0]  d;
    logic [63:0]         mag;
    logic [127:0]        acc;
    logic [127:0]        dens;
    acc = 0;
    if (mdl_count == 0) begin
      a.density = 32'd0;
      a.empty_flag = 1'b1;
      return a;
    end
    for (int i = 0; i < mdl_count; i++) begin
      d = $signed({{2{mdl_store[i][31]}}, mdl_store[i]}) - $signed({{2{q[31]}}, q});
      mag = d[33] ? 64'(-d) : 64'(d);
      if (mag < 64'(mdl_half_window)) acc += kernel_weight(mag);
    end
    dens = ((acc * 128'(mdl_inv_norm)) / mdl_count) >> 24;
    a.density = (dens > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : dens[31:0];
    a.empty_flag = 1'b0;
    return a;
  endfunction

  task automatic apply_item(gkde_pkg::opcode_t op, logic [31:0] pos);
    case (op)
      gkde_pkg::OP_CLEAR: begin
        mdl_count = 0;
      end
      gkde_pkg::OP_LOAD: begin
        n_loads++;
        if (mdl_count < gkde_pkg::MAX_SAMPLES) begin
          mdl_store[mdl_count] = pos;
          mdl_count++;
        end
      end
      gkde_pkg::OP_QUERY: begin
        n_queries++;
        awaited_answers.push_back(density_at(pos));
      end
      default: ;
    endcase
  endtask

  // input driver and output ready driver
  always @(negedge clk) begin
    if (rst_n && (!in_bus.valid || in_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_bus.valid <= 1'b1;
        in_bus.opcode <= pending_items[0].op;
        in_bus.value <= pending_items[0].pos;
        void'(pending_items.pop_front());
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor and checker
  always @(posedge clk) begin
    kde_answer_t exp_a;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
    in_taken <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        n_answers++;
        if (awaited_answers.size() == 0) begin
          $error("unexpected item: density %0h empty_flag %0b", out_bus.density,
                 out_bus.empty_flag);
          errors++;
        end else begin
          exp_a = awaited_answers.pop_front();
          if (out_bus.density !== exp_a.density) begin
            $error("density: expected %0h actual %0h", exp_a.density, out_bus.density);
            errors++;
          end
          if (out_bus.empty_flag !== exp_a.empty_flag) begin
            $error("empty_flag: expected %0b actual %0b", exp_a.empty_flag,
                   out_bus.empty_flag);
            errors++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) apply_item(in_bus.opcode, in_bus.value);
    end
  end

  task automatic queue_item(gkde_pkg::opcode_t op, logic [31:0] pos);
    kde_item_t it;
    it.op = op;
    it.pos = pos;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(gkde_pkg::cfg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    n_cfg++;
    case (idx)
      gkde_pkg::REG_HALF_WINDOW: mdl_half_window = data[30:0];
      gkde_pkg::REG_INV_TWO_VAR: mdl_inv_two_var = data;
      gkde_pkg::REG_INV_NORM:    mdl_inv_norm = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain_all();
    wait (pending_items.size() == 0 && !in_bus.valid && awaited_answers.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] near(logic [31:0] center, int spread);
    return center + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
  endfunction

  // clustered sample sets with queries nearby, plus some noise
  task automatic queue_random(int count);
    int          made;
    int          n;
    logic [31:0] c;
    made = 0;
    while (made < count) begin
      if ($urandom_range(9) == 0) begin
        queue_item(gkde_pkg::opcode_t'($urandom_range(3)), $urandom);
        made++;
      end else begin
        c = ($urandom_range(3) == 0) ? $urandom : near(32'd0, 1 << 20);
        if ($urandom_range(2) != 0) begin
          queue_item(gkde_pkg::OP_CLEAR, $urandom);
          made++;
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 16);
        for (int i = 0; i < n; i++) queue_item(gkde_pkg::OP_LOAD, near(c, 5 << 16));
        made += n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) queue_item(gkde_pkg::OP_QUERY, near(c, 4 << 16));
        made += n;
      end
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.opcode = gkde_pkg::OP_CLEAR;
    in_bus.value = 32'd0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = gkde_pkg::REG_HALF_WINDOW;
    cfg_bus.data = 32'd0;
    for (int i = 0; i < gkde_pkg::KERNEL_TABLE_SIZE; i++) kern_rom[i] = exp_level(i);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    queue_item(gkde_pkg::OP_QUERY, 32'd0);
    queue_item(OP_NONE, 32'hFFFF_FFFF);
    queue_item(gkde_pkg::OP_LOAD, 32'h8000_0000);
    queue_item(gkde_pkg::OP_LOAD, 32'h7FFF_FFFF);
    queue_item(gkde_pkg::OP_QUERY, 32'h8000_0000);
    queue_item(gkde_pkg::OP_QUERY, 32'h7FFF_FFFF);
    queue_item(gkde_pkg::OP_LOAD, 32'h0000_0000);
    queue_item(gkde_pkg::OP_LOAD, 32'hFFFF_FFFF);
    queue_item(gkde_pkg::OP_LOAD, 32'h0001_0000);
    queue_item(gkde_pkg::OP_LOAD, 32'h0002_FFFF);
    queue_item(gkde_pkg::OP_LOAD, 32'h0003_0000);
    queue_item(gkde_pkg::OP_QUERY, 32'h0000_0000);
    queue_item(gkde_pkg::OP_QUERY, 32'h0000_8000);
    queue_item(gkde_pkg::OP_CLEAR, 32'h5555_5555);
    queue_item(gkde_pkg::OP_QUERY, 32'h0000_0000);
    queue_item(gkde_pkg::OP_LOAD, 32'h0000_0000);
    queue_item(gkde_pkg::OP_QUERY, 32'h0000_0000);
    queue_item(gkde_pkg::OP_QUERY, 32'hFFFD_0001);
    queue_item(gkde_pkg::OP_QUERY, 32'hAAAA_AAAA);
    queue_random(110);
    drain_all();

    for (int ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: begin
          write_reg(gkde_pkg::REG_HALF_WINDOW, 32'h7FFF_FFFF);
          write_reg(gkde_pkg::REG_INV_TWO_VAR, 32'hFFFF_FFFF);
          write_reg(gkde_pkg::REG_INV_NORM, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(gkde_pkg::REG_HALF_WINDOW, 32'd0);
          write_reg(gkde_pkg::REG_INV_TWO_VAR, 32'd0);
          write_reg(gkde_pkg::REG_INV_NORM, 32'd0);
          write_reg(REG_NONE, 32'h1234_5678);
        end
        3: begin
          write_reg(gkde_pkg::REG_HALF_WINDOW, 32'($urandom_range(1 << 16, 1 << 20)));
          write_reg(gkde_pkg::REG_INV_TWO_VAR, 32'($urandom_range(1 << 20, 1 << 26)));
          write_reg(gkde_pkg::REG_INV_NORM, $urandom);
        end
        default: begin
          write_reg(gkde_pkg::REG_HALF_WINDOW, 32'h7FFF_FFFF);
          write_reg(gkde_pkg::REG_INV_TWO_VAR, 32'd0);
          write_reg(gkde_pkg::REG_INV_NORM, 32'hFFFF_FFFF);
        end
      endcase
      send_idle_pct = (ph == 1) ? 66 : ((ph == 3) ? 35 : 0);
      recv_idle_pct = (ph == 2) ? 66 : ((ph == 3) ? 35 : 0);
      queue_random(110);
      drain_all();
    end

    $display("covered %0d loads, %0d queries, %0d answers checked, %0d register writes",
             n_loads, n_queries, n_answers, n_cfg);
    $display("across five idling and register settings");
    if (errors == 0 && awaited_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
